FILE: rtl/core/ascp_pkg.sv
// ============================================================================
// ascp_pkg: shared types and constants of the ASCII servo command parser
// Parse phases, character codes, register indexes and the item formats that
// travel between the parser front end, the queues and the executor.
// ============================================================================
package ascp_pkg;

    // Parse phases, one-hot
    typedef enum logic [5:0] {
        PH_CMD    = 6'b000001,
        PH_WS     = 6'b000010,
        PH_SIGN   = 6'b000100,
        PH_DIGITS = 6'b001000,
        PH_DONE   = 6'b010000,
        PH_FAIL   = 6'b100000
    } phase_t;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VTAB  = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Command characters
    localparam logic [7:0] CMD_CENTER = 8'h30;
    localparam logic [7:0] CMD_BOTH_A = 8'h31;
    localparam logic [7:0] CMD_BOTH_B = 8'h32;
    localparam logic [7:0] CMD_MIR_R  = 8'h33;
    localparam logic [7:0] CMD_MIR_L  = 8'h34;
    localparam logic [7:0] CMD_STOW   = 8'h38;
    localparam logic [7:0] CMD_DEPLOY = 8'h39;

    // Action codes
    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_SERVO = 2'd1,
        ACT_AUX   = 2'd2
    } action_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_CENTER = 2'd0,
        REG_MIRROR = 2'd1,
        REG_DEPLOY = 2'd2,
        REG_STOW   = 2'd3
    } reg_index_t;

    localparam logic [15:0] CENTER_RESET = 16'd1500;
    localparam logic [15:0] MIRROR_RESET = 16'd3000;
    localparam logic [15:0] DEPLOY_RESET = 16'd500;
    localparam logic [15:0] STOW_RESET   = 16'd1500;

    // Magnitude limit: 2^31
    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

    // Queue depths
    localparam int LINE_Q_DEPTH = 2;
    localparam int RES_Q_DEPTH  = 2;

    // One finished line, as classified by the front end
    typedef struct packed {
        logic        has_num;
        logic [7:0]  cmd;
        logic        neg;
        logic [31:0] mag;
    } line_desc_t;

    // One result item
    typedef struct packed {
        action_t     action;
        logic [31:0] s1;
        logic [31:0] s2;
        logic [15:0] aux;
    } result_t;

    // Configuration write
    typedef struct packed {
        logic        valid;
        reg_index_t  index;
        logic [15:0] data;
    } cfg_wr_t;

endpackage

FILE: rtl/core/ascp_fifo.sv
// ============================================================================
// ascp_fifo: small synchronous queue
// Register-based FIFO with full and empty flags; push and pop may occur in
// the same cycle. Head entry is presented combinationally.
// ============================================================================
module ascp_fifo #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: rtl/core/ascp_front.sv
// ============================================================================
// ascp_front: byte parser
// Streams bytes through the line parser and hands one line descriptor to the
// line queue on every carriage return or line feed.
// ============================================================================
module ascp_front #(
    parameter int LINE_CAPACITY = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [7:0]         in_byte,
    input  logic               q_full,
    output logic               in_full,
    output logic               q_push,
    output ascp_pkg::line_desc_t q_desc
);
    import ascp_pkg::*;

    localparam int CNT_W = $clog2(LINE_CAPACITY);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    phase_t           phase_reg, phase_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic             neg_reg, neg_next;
    logic [31:0]      mag_reg, mag_next;

    logic             accept, term, is_blank, is_digit;
    logic [35:0]      acc;
    logic [31:0]      mag_acc;

    assign in_full  = q_full;
    assign accept   = in_valid & ~q_full;
    assign term     = (in_byte == CH_LF) || (in_byte == CH_CR);
    assign is_blank = in_byte inside {CH_SPACE, CH_TAB, CH_VTAB, CH_FF};
    assign is_digit = in_byte inside {[CH_ZERO:CH_NINE]};

    // mag * 10 + digit, saturated at 2^31
    assign acc     = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0}
                   + {32'd0, in_byte[3:0]};
    assign mag_acc = (acc > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : acc[31:0];

    assign q_push          = accept & term;
    assign q_desc.has_num  = (phase_reg == PH_DIGITS) || (phase_reg == PH_DONE);
    assign q_desc.cmd      = cmd_reg;
    assign q_desc.neg      = neg_reg;
    assign q_desc.mag      = mag_reg;

    always_comb
    begin
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        if (accept)
        begin
            if (term)
            begin
                cnt_next   = '0;
                phase_next = PH_CMD;
                cmd_next   = '0;
                neg_next   = 1'b0;
                mag_next   = '0;
            end
            else if (cnt_reg != CNT_W'(LINE_CAPACITY - 1))
            begin
                cnt_next = cnt_reg + 1'b1;
                case (phase_reg)
                    PH_CMD:
                    begin
                        if (in_byte == CH_NUL)
                        begin
                            phase_next = PH_FAIL;
                        end
                        else
                        begin
                            cmd_next   = in_byte;
                            phase_next = PH_WS;
                        end
                    end
                    PH_WS:
                    begin
                        if (is_blank)
                        begin
                            phase_next = PH_WS;
                        end
                        else if (in_byte == CH_PLUS)
                        begin
                            phase_next = PH_SIGN;
                        end
                        else if (in_byte == CH_MINUS)
                        begin
                            neg_next   = 1'b1;
                            phase_next = PH_SIGN;
                        end
                        else if (is_digit)
                        begin
                            mag_next   = mag_acc;
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            phase_next = PH_FAIL;
                        end
                    end
                    PH_SIGN:
                    begin
                        if (is_digit)
                        begin
                            mag_next   = mag_acc;
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            phase_next = PH_FAIL;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            mag_next = mag_acc;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            phase_reg <= PH_CMD;
            cmd_reg   <= '0;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
        end
    end

endmodule

FILE: rtl/core/ascp_back.sv
// ============================================================================
// ascp_back: command executor
// Holds the configuration registers, takes line descriptors from the line
// queue and turns each into one result item for the result queue.
// ============================================================================
module ascp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ascp_pkg::cfg_wr_t    cfg,
    input  logic                 q_empty,
    input  ascp_pkg::line_desc_t q_desc,
    output logic                 q_pop,
    input  logic                 r_full,
    output logic                 r_push,
    output ascp_pkg::result_t    r_item
);
    import ascp_pkg::*;

    logic [15:0] center_reg, mirror_reg, deploy_reg, stow_reg;
    logic [31:0] num, mirrored;

    assign q_pop  = ~q_empty & ~r_full;
    assign r_push = q_pop;

    // Signed number: negative wraps, positive clamps at 2^31-1
    assign num      = q_desc.neg ? (32'd0 - q_desc.mag)
                                 : (q_desc.mag[31] ? POS_MAX : q_desc.mag);
    assign mirrored = {16'd0, mirror_reg} - num;

    always_comb
    begin
        r_item.action = ACT_NONE;
        r_item.s1     = '0;
        r_item.s2     = '0;
        r_item.aux    = '0;
        if (q_desc.has_num)
        begin
            case (q_desc.cmd)
                CMD_BOTH_A, CMD_BOTH_B:
                begin
                    r_item.action = ACT_SERVO;
                    r_item.s1     = num;
                    r_item.s2     = num;
                end
                CMD_MIR_R:
                begin
                    r_item.action = ACT_SERVO;
                    r_item.s1     = num;
                    r_item.s2     = mirrored;
                end
                CMD_MIR_L:
                begin
                    r_item.action = ACT_SERVO;
                    r_item.s1     = mirrored;
                    r_item.s2     = num;
                end
                CMD_CENTER:
                begin
                    r_item.action = ACT_SERVO;
                    r_item.s1     = {16'd0, center_reg};
                    r_item.s2     = {16'd0, center_reg};
                end
                CMD_DEPLOY:
                begin
                    r_item.action = ACT_AUX;
                    r_item.aux    = deploy_reg;
                end
                CMD_STOW:
                begin
                    r_item.action = ACT_AUX;
                    r_item.aux    = stow_reg;
                end
                default:
                begin
                    r_item.action = ACT_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= CENTER_RESET;
            mirror_reg <= MIRROR_RESET;
            deploy_reg <= DEPLOY_RESET;
            stow_reg   <= STOW_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_CENTER: center_reg <= cfg.data;
                REG_MIRROR: mirror_reg <= cfg.data;
                REG_DEPLOY: deploy_reg <= cfg.data;
                REG_STOW:   stow_reg   <= cfg.data;
                default:    center_reg <= center_reg;
            endcase
        end
    end

endmodule

FILE: rtl/core/ascii_servo_command_parser_core.sv
// ============================================================================
// ascii_servo_command_parser_core: ASCII servo command parser
// Parses serial text lines into servo and auxiliary pulse updates.
// ============================================================================
// Throughput: one byte per cycle while the line queue has room; the parser's
//   combinational multiply-by-ten-and-add on the magnitude register sets that figure.
// Path: an accepted line terminator is written into the line queue; the executor
//   then writes its result into the result queue, whose head drives the result ports.
// Reset (rst_n low, async): parser returns to "expect command character",
//   both queues empty, configuration registers back to their defaults.
module ascii_servo_command_parser_core #(
    parameter int LINE_CAPACITY = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // byte input, queue style
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    // result output, queue style
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  action,
    output logic [31:0] servo_one_pulse,
    output logic [31:0] servo_two_pulse,
    output logic [15:0] aux_pulse,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import ascp_pkg::*;

    localparam int DESC_W = $bits(line_desc_t);
    localparam int RES_W  = $bits(result_t);

    // Front end -> line queue
    logic        lq_push, lq_full, lq_pop, lq_empty;
    line_desc_t  lq_wdesc, lq_rdesc;

    // Executor -> result queue
    logic        rq_push, rq_full;
    result_t     rq_witem, rq_ritem;

    cfg_wr_t     cfg_wr;

    // Registers must only change while idle; the block does not enforce this, and writes are always accepted.
    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid & cfg_ready;
    assign cfg_wr.index = reg_index_t'(cfg_index);
    assign cfg_wr.data  = cfg_data;

    // Parser: one byte per cycle, stalls only when the line queue is full.
    ascp_front #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (push),
        .in_byte  (rx_byte),
        .q_full   (lq_full),
        .in_full  (full),
        .q_push   (lq_push),
        .q_desc   (lq_wdesc)
    );

    // Line queue decouples parsing from execution.
    ascp_fifo #(
        .DEPTH (LINE_Q_DEPTH),
        .WIDTH (DESC_W)
    ) u_line_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (lq_push),
        .wdata (lq_wdesc),
        .full  (lq_full),
        .pop   (lq_pop),
        .rdata (lq_rdesc),
        .empty (lq_empty)
    );

    // Executor: one line per cycle while the result queue has room.
    ascp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_wr),
        .q_empty (lq_empty),
        .q_desc  (lq_rdesc),
        .q_pop   (lq_pop),
        .r_full  (rq_full),
        .r_push  (rq_push),
        .r_item  (rq_witem)
    );

    // Result queue: its head drives the result ports.
    ascp_fifo #(
        .DEPTH (RES_Q_DEPTH),
        .WIDTH (RES_W)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .wdata (rq_witem),
        .full  (rq_full),
        .pop   (pop),
        .rdata (rq_ritem),
        .empty (empty)
    );

    assign action          = rq_ritem.action;
    assign servo_one_pulse = rq_ritem.s1;
    assign servo_two_pulse = rq_ritem.s2;
    assign aux_pulse       = rq_ritem.aux;

endmodule
